@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the projector blocks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define PVP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every clock edge, reset included
`define PVP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/pvp_pkg.sv @@
// ----------------------------------------------------------------------------
// pvp_pkg
// widths, reset values, types and helpers of the vertex projector
// ----------------------------------------------------------------------------
package pvp_pkg;

   // field widths
   localparam int COORD_WIDTH  = 24;
   localparam int COEF_WIDTH   = 16;
   localparam int NEAR_PLANE   = 256;
   localparam int COEF_FRAC    = COEF_WIDTH - 2;
   localparam int DEPTH_WIDTH  = COORD_WIDTH + 8;
   localparam int SIZE_FIELD   = 12;
   localparam int FOCAL_WIDTH  = 24;
   localparam int SCREEN_WIDTH = 2 * SIZE_FIELD;
   localparam int ROW_WIDTH    = 3 * COEF_WIDTH;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = ROW_WIDTH;

   // datapath widths
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = DIFF_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH   = PROD_WIDTH + 2;
   localparam int VIEW_WIDTH  = ACC_WIDTH - COEF_FRAC;
   localparam int SCALE_WIDTH = VIEW_WIDTH + FOCAL_WIDTH + 1;
   localparam int NUM_WIDTH   = SCALE_WIDTH + 1;
   localparam int MAG_WIDTH   = NUM_WIDTH - 1;
   localparam int DEN_WIDTH   = VIEW_WIDTH;
   localparam int QUO_WIDTH   = COORD_WIDTH + 2;
   localparam int HI_WIDTH    = MAG_WIDTH - QUO_WIDTH;
   localparam int REM_WIDTH   = (HI_WIDTH > DEN_WIDTH) ? HI_WIDTH : DEN_WIDTH;
   localparam int STEP_WIDTH  = REM_WIDTH + 1;
   localparam int CEN_SHIFT   = 7;
   localparam int SUM_WIDTH   = QUO_WIDTH + 3;

   // reset values
   localparam logic [ROW_WIDTH-1:0] COEF_ONE     = ROW_WIDTH'(1) << COEF_FRAC;
   localparam logic [ROW_WIDTH-1:0] VIEW_X_RESET = COEF_ONE;
   localparam logic [ROW_WIDTH-1:0] VIEW_Y_RESET = COEF_ONE << COEF_WIDTH;
   localparam logic [ROW_WIDTH-1:0] VIEW_Z_RESET = COEF_ONE << (2 * COEF_WIDTH);
   localparam logic [COORD_WIDTH-1:0] CAM_Z_RESET = COORD_WIDTH'(-50 * 256);
   localparam logic [FOCAL_WIDTH-1:0] FOCAL_RESET = FOCAL_WIDTH'(70943);
   localparam logic [SCREEN_WIDTH-1:0] SCREEN_RESET = {SIZE_FIELD'(240), SIZE_FIELD'(320)};

   localparam logic signed [ACC_WIDTH-1:0]  ROUND_HALF = ACC_WIDTH'(1) << (COEF_FRAC - 1);
   localparam logic signed [VIEW_WIDTH-1:0] NEAR_VIEW  = VIEW_WIDTH'(NEAR_PLANE);
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      REG_VIEW_X,
      REG_VIEW_Y,
      REG_VIEW_Z,
      REG_CAM_X,
      REG_CAM_Y,
      REG_CAM_Z,
      REG_FOCAL,
      REG_SCREEN
   } csr_reg_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0]           view_x;
      logic [ROW_WIDTH-1:0]           view_y;
      logic [ROW_WIDTH-1:0]           view_z;
      logic signed [COORD_WIDTH-1:0]  cam_x;
      logic signed [COORD_WIDTH-1:0]  cam_y;
      logic signed [COORD_WIDTH-1:0]  cam_z;
      logic [FOCAL_WIDTH-1:0]         focal;
      logic [SCREEN_WIDTH-1:0]        screen;
   } cfg_type;

   // numerators in magnitude form, ready for the divider
   typedef struct packed {
      logic [MAG_WIDTH-1:0]          mag_x;
      logic [MAG_WIDTH-1:0]          mag_y;
      logic                          neg_x;
      logic                          neg_y;
      logic [DEN_WIDTH-1:0]          den;
      logic signed [VIEW_WIDTH-1:0]  vz;
      logic                          clip;
   } num_type;

   // floored quotients with sign restored
   typedef struct packed {
      logic signed [QUO_WIDTH:0]     q_x;
      logic signed [QUO_WIDTH:0]     q_y;
      logic signed [VIEW_WIDTH-1:0]  vz;
      logic                          clip;
   } quot_type;

   function automatic logic signed [COEF_WIDTH-1:0] coef_of(
      input logic [ROW_WIDTH-1:0] row,
      input int                   k
   );
      return row[k*COEF_WIDTH +: COEF_WIDTH];
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic [SUM_WIDTH-COORD_WIDTH:0] upper;
      upper = v[SUM_WIDTH-1:COORD_WIDTH-1];
      if (upper == '0 || upper == '1) begin
         return v[COORD_WIDTH-1:0];
      end else if (v[SUM_WIDTH-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

endpackage

@@ rtl/perspective_vertex_projector_unit.sv @@
// ----------------------------------------------------------------------------
// perspective_vertex_projector_unit
// pinhole camera projection of world-space vertices to screen coordinates
// ----------------------------------------------------------------------------
// One vertex word in, one screen word out, one word per clock sustained while rsp_stall stays low.
// An accepted req word passes through 5 transform stages (camera offset,
// matrix products, row sums, focal scale, numerator setup), COORD_WIDTH + 3
// = 27 divider stages (an overflow check on the high part of the numerator,
// then 26 stages that each retire one quotient bit for the x and y lanes side
// by side), and one output register on its way to rsp_valid. The divider
// depth sets the latency. A two-word output queue sits at the end:
// the pipeline keeps taking words while one result waits on rsp_stall and
// freezes, holding req_stall high, only once two results are queued.
// Configuration registers are written through the csr port, which is always
// ready; write them only while no word is in flight.
`include "assert_macros.svh"

module perspective_vertex_projector_unit import pvp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,

   // vertex words
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,

   // projected words
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_screen_x,
   output logic signed [COORD_WIDTH-1:0] rsp_screen_y,
   output logic signed [DEPTH_WIDTH-1:0] rsp_view_depth,
   output logic                          rsp_clipped,

   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_data
);

   // configuration registers
   logic [ROW_WIDTH-1:0]          view_x_ff, view_y_ff, view_z_ff;
   logic signed [COORD_WIDTH-1:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic [FOCAL_WIDTH-1:0]        focal_ff;
   logic [SCREEN_WIDTH-1:0]       screen_ff;
   cfg_type                       cfg;

   // pipeline hookup
   logic     advance;
   logic     xf_valid, dv_valid;
   num_type  xf_num;
   quot_type dv_quot;

   // the register file never back-pressures
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_x_ff <= VIEW_X_RESET;
         view_y_ff <= VIEW_Y_RESET;
         view_z_ff <= VIEW_Z_RESET;
         cam_x_ff  <= '0;
         cam_y_ff  <= '0;
         cam_z_ff  <= CAM_Z_RESET;
         focal_ff  <= FOCAL_RESET;
         screen_ff <= SCREEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_addr))
            REG_VIEW_X: view_x_ff <= csr_data[ROW_WIDTH-1:0];
            REG_VIEW_Y: view_y_ff <= csr_data[ROW_WIDTH-1:0];
            REG_VIEW_Z: view_z_ff <= csr_data[ROW_WIDTH-1:0];
            REG_CAM_X:  cam_x_ff  <= csr_data[COORD_WIDTH-1:0];
            REG_CAM_Y:  cam_y_ff  <= csr_data[COORD_WIDTH-1:0];
            REG_CAM_Z:  cam_z_ff  <= csr_data[COORD_WIDTH-1:0];
            REG_FOCAL:  focal_ff  <= csr_data[FOCAL_WIDTH-1:0];
            REG_SCREEN: screen_ff <= csr_data[SCREEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.view_x = view_x_ff;
      cfg.view_y = view_y_ff;
      cfg.view_z = view_z_ff;
      cfg.cam_x  = cam_x_ff;
      cfg.cam_y  = cam_y_ff;
      cfg.cam_z  = cam_z_ff;
      cfg.focal  = focal_ff;
      cfg.screen = screen_ff;
   end

   // a word enters whenever the whole pipe moves
   assign req_stall = !advance;

   // offset, rotate, clip test, numerators
   pvp_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .point_z   (req_point_z),
      .cfg       (cfg),
      .out_valid (xf_valid),
      .out_num   (xf_num)
   );

   // floor((2*v*f + z) / (2*z)) for both screen axes
   pvp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (xf_valid),
      .in_num    (xf_num),
      .out_valid (dv_valid),
      .out_quot  (dv_quot)
   );

   // centre, saturate, queue toward the rsp side
   pvp_finish u_finish (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (dv_valid),
      .in_quot        (dv_quot),
      .screen         (screen_ff),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_screen_x   (rsp_screen_x),
      .rsp_screen_y   (rsp_screen_y),
      .rsp_view_depth (rsp_view_depth),
      .rsp_clipped    (rsp_clipped)
   );

   // no input taken while the queue is full
   `PVP_ASSERT(a_full_no_take, (rsp_valid && req_stall) |-> !advance, "pipeline moved with full output queue")

endmodule

@@ rtl/pvp_xform.sv @@
// ----------------------------------------------------------------------------
// pvp_xform
// camera offset, view matrix, depth clip test and numerator setup
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pvp_xform import pvp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic signed [COORD_WIDTH-1:0] point_z,
   input  cfg_type                       cfg,
   output logic                          out_valid,
   output num_type                       out_num
);

   localparam int NST = 5;

   logic [NST-1:0] vld_ff;

   logic [ROW_WIDTH-1:0] rows [3];

   logic signed [DIFF_WIDTH-1:0] diff_in [3];
   logic signed [DIFF_WIDTH-1:0] diff_ff [3];

   logic signed [PROD_WIDTH-1:0] prod_in [3][3];
   logic signed [PROD_WIDTH-1:0] prod_ff [3][3];

   logic signed [ACC_WIDTH-1:0]  acc_sum [3];
   logic signed [VIEW_WIDTH-1:0] view_in [3];
   logic signed [VIEW_WIDTH-1:0] view_ff [3];

   logic signed [SCALE_WIDTH-1:0] scale_x_in, scale_y_in, scale_x_ff, scale_y_ff;
   logic signed [VIEW_WIDTH-1:0]  vz_in, vz_ff;
   logic                          clip_in, clip_ff;

   logic signed [NUM_WIDTH-1:0] num_x, num_y;
   num_type                     num_in, num_ff;

   // valid bits shift with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_comb begin
      rows[0] = cfg.view_x;
      rows[1] = cfg.view_y;
      rows[2] = cfg.view_z;
   end

   // stage 0: offset from camera
   always_comb begin
      diff_in[0] = DIFF_WIDTH'(point_x) - DIFF_WIDTH'(cfg.cam_x);
      diff_in[1] = DIFF_WIDTH'(point_y) - DIFF_WIDTH'(cfg.cam_y);
      diff_in[2] = DIFF_WIDTH'(point_z) - DIFF_WIDTH'(cfg.cam_z);
   end

   // stage 1: nine weight products
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[r][k] = coef_of(rows[r], k) * diff_ff[k];
         end
      end
   end

   // stage 2: row sums, round half up to q.8
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_sum[r] = ACC_WIDTH'(prod_ff[r][0]) + ACC_WIDTH'(prod_ff[r][1])
                    + ACC_WIDTH'(prod_ff[r][2]) + ROUND_HALF;
         view_in[r] = acc_sum[r][ACC_WIDTH-1:COEF_FRAC];
      end
   end

   // stage 3: scale by focal length, near plane test
   always_comb begin
      scale_x_in = view_ff[0] * $signed({1'b0, cfg.focal});
      scale_y_in = view_ff[1] * $signed({1'b0, cfg.focal});
      vz_in      = view_ff[2];
      clip_in    = view_ff[2] < NEAR_VIEW;
   end

   // stage 4: 2*v*f + depth, folded to magnitude for floor division
   always_comb begin
      num_x = $signed({scale_x_ff, 1'b0}) + NUM_WIDTH'(vz_ff);
      num_y = $signed({scale_y_ff, 1'b0}) + NUM_WIDTH'(vz_ff);
      num_in.neg_x = num_x[NUM_WIDTH-1];
      num_in.neg_y = num_y[NUM_WIDTH-1];
      num_in.mag_x = num_x[NUM_WIDTH-1] ? ~num_x[MAG_WIDTH-1:0] : num_x[MAG_WIDTH-1:0];
      num_in.mag_y = num_y[NUM_WIDTH-1] ? ~num_y[MAG_WIDTH-1:0] : num_y[MAG_WIDTH-1:0];
      num_in.den   = {vz_ff[VIEW_WIDTH-2:0], 1'b0};
      num_in.vz    = vz_ff;
      num_in.clip  = clip_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff    <= diff_in;
         prod_ff    <= prod_in;
         view_ff    <= view_in;
         scale_x_ff <= scale_x_in;
         scale_y_ff <= scale_y_in;
         vz_ff      <= vz_in;
         clip_ff    <= clip_in;
         num_ff     <= num_in;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_num   = num_ff;

   `PVP_ASSERT(a_xform_flush, $past(reset) |-> (vld_ff == '0), "xform stages not flushed by reset")

endmodule

@@ rtl/pvp_divider.sv @@
// ----------------------------------------------------------------------------
// pvp_divider
// pipelined restoring divider, one quotient bit per stage, two lanes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pvp_divider import pvp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  num_type  in_num,
   output logic     out_valid,
   output quot_type out_quot
);

   localparam int NST = QUO_WIDTH + 1;

   typedef struct packed {
      logic [REM_WIDTH-1:0]          rem_x;
      logic [REM_WIDTH-1:0]          rem_y;
      logic [QUO_WIDTH-1:0]          lq_x;
      logic [QUO_WIDTH-1:0]          lq_y;
      logic                          ovf_x;
      logic                          ovf_y;
      logic                          neg_x;
      logic                          neg_y;
      logic [DEN_WIDTH-1:0]          den;
      logic signed [VIEW_WIDTH-1:0]  vz;
      logic                          clip;
   } div_stage_type;

   logic [NST-1:0] vld_ff;
   div_stage_type  stg_in [NST];
   div_stage_type  stg_ff [NST];

   logic [REM_WIDTH-1:0] hi_x, hi_y, den_in;
   logic [QUO_WIDTH-1:0] qmag_x, qmag_y;

   // returns {remainder, shifted dividend/quotient}
   function automatic logic [REM_WIDTH+QUO_WIDTH-1:0] div_step(
      input logic [REM_WIDTH-1:0] rem,
      input logic [QUO_WIDTH-1:0] lq,
      input logic [DEN_WIDTH-1:0] den
   );
      logic [STEP_WIDTH-1:0] trial;
      logic [STEP_WIDTH-1:0] diff;
      trial = {rem, lq[QUO_WIDTH-1]};
      diff  = trial - STEP_WIDTH'(den);
      if (!diff[REM_WIDTH]) begin
         return {diff[REM_WIDTH-1:0], lq[QUO_WIDTH-2:0], 1'b1};
      end else begin
         return {trial[REM_WIDTH-1:0], lq[QUO_WIDTH-2:0], 1'b0};
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   // first stage: high part as starting remainder, overflow when quotient
   // would not fit in the quotient width
   always_comb begin
      hi_x   = REM_WIDTH'(in_num.mag_x[MAG_WIDTH-1:QUO_WIDTH]);
      hi_y   = REM_WIDTH'(in_num.mag_y[MAG_WIDTH-1:QUO_WIDTH]);
      den_in = REM_WIDTH'(in_num.den);

      stg_in[0].rem_x = hi_x;
      stg_in[0].rem_y = hi_y;
      stg_in[0].lq_x  = in_num.mag_x[QUO_WIDTH-1:0];
      stg_in[0].lq_y  = in_num.mag_y[QUO_WIDTH-1:0];
      stg_in[0].ovf_x = hi_x >= den_in;
      stg_in[0].ovf_y = hi_y >= den_in;
      stg_in[0].neg_x = in_num.neg_x;
      stg_in[0].neg_y = in_num.neg_y;
      stg_in[0].den   = in_num.den;
      stg_in[0].vz    = in_num.vz;
      stg_in[0].clip  = in_num.clip;

      for (int s = 1; s < NST; s++) begin
         stg_in[s] = stg_ff[s-1];
         {stg_in[s].rem_x, stg_in[s].lq_x} =
            div_step(stg_ff[s-1].rem_x, stg_ff[s-1].lq_x, stg_ff[s-1].den);
         {stg_in[s].rem_y, stg_in[s].lq_y} =
            div_step(stg_ff[s-1].rem_y, stg_ff[s-1].lq_y, stg_ff[s-1].den);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stg_ff <= stg_in;
      end
   end

   // clamp on overflow, then floor for negative numerators is -q-1
   always_comb begin
      qmag_x = stg_ff[NST-1].ovf_x ? '1 : stg_ff[NST-1].lq_x;
      qmag_y = stg_ff[NST-1].ovf_y ? '1 : stg_ff[NST-1].lq_y;
      out_quot.q_x  = stg_ff[NST-1].neg_x ? ~{1'b0, qmag_x} : {1'b0, qmag_x};
      out_quot.q_y  = stg_ff[NST-1].neg_y ? ~{1'b0, qmag_y} : {1'b0, qmag_y};
      out_quot.vz   = stg_ff[NST-1].vz;
      out_quot.clip = stg_ff[NST-1].clip;
   end

   assign out_valid = vld_ff[NST-1];

   `PVP_ASSERT(a_div_rem_x, (vld_ff[NST-1] && !stg_ff[NST-1].clip && !stg_ff[NST-1].ovf_x) |-> (stg_ff[NST-1].rem_x < REM_WIDTH'(stg_ff[NST-1].den)), "divider x remainder not below divisor")

endmodule

@@ rtl/pvp_finish.sv @@
// ----------------------------------------------------------------------------
// pvp_finish
// screen centre offset, saturation, clip zeroing and two-word output queue
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pvp_finish import pvp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  quot_type                      in_quot,
   input  logic [SCREEN_WIDTH-1:0]       screen,
   output logic                          advance,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_screen_x,
   output logic signed [COORD_WIDTH-1:0] rsp_screen_y,
   output logic signed [DEPTH_WIDTH-1:0] rsp_view_depth,
   output logic                          rsp_clipped
);

   localparam logic [1:0] QUEUE_EMPTY = 2'd0;
   localparam logic [1:0] QUEUE_ONE   = 2'd1;
   localparam logic [1:0] QUEUE_FULL  = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] screen_x;
      logic signed [COORD_WIDTH-1:0] screen_y;
      logic signed [DEPTH_WIDTH-1:0] depth;
      logic                          clipped;
   } result_type;

   logic [SIZE_FIELD+CEN_SHIFT-1:0] cen_x, cen_y;
   logic signed [SUM_WIDTH-1:0]     sum_x, sum_y;
   result_type                      res_in;
   result_type                      head_ff, tail_ff;
   logic [1:0]                      count_in, count_ff;
   logic                            push, pop;

   always_comb begin
      cen_x = {screen[SIZE_FIELD-1:0], {CEN_SHIFT{1'b0}}};
      cen_y = {screen[SCREEN_WIDTH-1:SIZE_FIELD], {CEN_SHIFT{1'b0}}};
      sum_x = SUM_WIDTH'(in_quot.q_x) + $signed(SUM_WIDTH'(cen_x));
      sum_y = $signed(SUM_WIDTH'(cen_y)) - SUM_WIDTH'(in_quot.q_y);

      res_in.depth   = DEPTH_WIDTH'(in_quot.vz);
      res_in.clipped = in_quot.clip;
      if (in_quot.clip) begin
         res_in.screen_x = '0;
         res_in.screen_y = '0;
      end else begin
         res_in.screen_x = sat_coord(sum_x);
         res_in.screen_y = sat_coord(sum_y);
      end
   end

   // pipeline moves while the queue has room
   assign advance   = count_ff != QUEUE_FULL;
   assign rsp_valid = count_ff != QUEUE_EMPTY;
   assign push      = advance && in_valid;
   assign pop       = rsp_valid && !rsp_stall;
   assign count_in  = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= QUEUE_EMPTY;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && (count_ff == QUEUE_EMPTY || (count_ff == QUEUE_ONE && pop))) begin
         head_ff <= res_in;
      end else if (pop) begin
         head_ff <= tail_ff;
      end
      if (push && count_ff == QUEUE_ONE && !pop) begin
         tail_ff <= res_in;
      end
   end

   assign rsp_screen_x   = head_ff.screen_x;
   assign rsp_screen_y   = head_ff.screen_y;
   assign rsp_view_depth = head_ff.depth;
   assign rsp_clipped    = head_ff.clipped;

   `PVP_ASSERT(a_clip_zero, (rsp_valid && rsp_clipped) |-> (rsp_screen_x == '0 && rsp_screen_y == '0), "clipped word with nonzero screen position")
   `PVP_ASSERT(a_depth_near, (rsp_valid && !rsp_clipped) |-> (rsp_view_depth >= $signed(DEPTH_WIDTH'(NEAR_PLANE))), "unclipped word in front of near plane")

endmodule

@@ bench/projection_checker.sv @@
// ----------------------------------------------------------------------------
// projection_checker
// watches the vertex, screen and register channels of the projector, keeps a
// copy of the camera setup and compares every screen word with its prediction
// ----------------------------------------------------------------------------
module projection_checker import pvp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,

   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [COORD_WIDTH-1:0] rsp_screen_x,
   input  logic signed [COORD_WIDTH-1:0] rsp_screen_y,
   input  logic signed [DEPTH_WIDTH-1:0] rsp_view_depth,
   input  logic                          rsp_clipped,

   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_data,

   output int unsigned                   mismatches,
   output int unsigned                   words_in_flight
);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] screen_x;
      logic signed [COORD_WIDTH-1:0] screen_y;
      logic signed [DEPTH_WIDTH-1:0] view_depth;
      logic                          clipped;
   } screen_word_type;

   typedef struct {
      screen_word_type word;
      int unsigned     seq;
   } pending_word_type;

   cfg_type          camera_setup;
   pending_word_type expected_words [$];
   pending_word_type fresh;
   pending_word_type oldest;
   int unsigned      vertex_count;

   // floor of num / den, den positive
   function automatic longint floor_quotient(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den != 0) && (num < 0)) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic longint clamp_signed(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   // one row of the view matrix, rounded half up to q.8
   function automatic longint rotate_row(logic [ROW_WIDTH-1:0] row,
                                         longint dx, longint dy, longint dz);
      logic signed [COEF_WIDTH-1:0] wx;
      logic signed [COEF_WIDTH-1:0] wy;
      logic signed [COEF_WIDTH-1:0] wz;
      longint                       acc;
      wx  = row[COEF_WIDTH-1:0];
      wy  = row[2*COEF_WIDTH-1:COEF_WIDTH];
      wz  = row[3*COEF_WIDTH-1:2*COEF_WIDTH];
      acc = longint'(wx) * dx + longint'(wy) * dy + longint'(wz) * dz;
      acc = acc + (longint'(1) <<< (COEF_FRAC - 1));
      return acc >>> COEF_FRAC;
   endfunction

   function automatic screen_word_type project_vertex(
      logic signed [COORD_WIDTH-1:0] px,
      logic signed [COORD_WIDTH-1:0] py,
      logic signed [COORD_WIDTH-1:0] pz,
      cfg_type                       c
   );
      longint          dx, dy, dz;
      longint          vx, vy, vz;
      longint          f, centre_x, centre_y;
      screen_word_type w;
      dx = longint'(px) - longint'($signed(c.cam_x));
      dy = longint'(py) - longint'($signed(c.cam_y));
      dz = longint'(pz) - longint'($signed(c.cam_z));
      vx = rotate_row(c.view_x, dx, dy, dz);
      vy = rotate_row(c.view_y, dx, dy, dz);
      vz = rotate_row(c.view_z, dx, dy, dz);
      w.view_depth = DEPTH_WIDTH'(clamp_signed(vz, DEPTH_WIDTH));
      if (vz < NEAR_PLANE || vz <= 0) begin
         w.screen_x = '0;
         w.screen_y = '0;
         w.clipped  = 1'b1;
      end else begin
         f        = longint'(c.focal);
         centre_x = longint'(c.screen[SIZE_FIELD-1:0]) <<< CEN_SHIFT;
         centre_y = longint'(c.screen[2*SIZE_FIELD-1:SIZE_FIELD]) <<< CEN_SHIFT;
         w.screen_x = COORD_WIDTH'(clamp_signed(
            floor_quotient(2 * vx * f + vz, 2 * vz) + centre_x, COORD_WIDTH));
         w.screen_y = COORD_WIDTH'(clamp_signed(
            centre_y - floor_quotient(2 * vy * f + vz, 2 * vz), COORD_WIDTH));
         w.clipped  = 1'b0;
      end
      return w;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         camera_setup = '{view_x: VIEW_X_RESET, view_y: VIEW_Y_RESET,
                          view_z: VIEW_Z_RESET, cam_x: '0, cam_y: '0,
                          cam_z: CAM_Z_RESET, focal: FOCAL_RESET,
                          screen: SCREEN_RESET};
         expected_words.delete();
         vertex_count = 0;
         mismatches   = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               REG_VIEW_X: camera_setup.view_x = csr_data[ROW_WIDTH-1:0];
               REG_VIEW_Y: camera_setup.view_y = csr_data[ROW_WIDTH-1:0];
               REG_VIEW_Z: camera_setup.view_z = csr_data[ROW_WIDTH-1:0];
               REG_CAM_X:  camera_setup.cam_x  = csr_data[COORD_WIDTH-1:0];
               REG_CAM_Y:  camera_setup.cam_y  = csr_data[COORD_WIDTH-1:0];
               REG_CAM_Z:  camera_setup.cam_z  = csr_data[COORD_WIDTH-1:0];
               REG_FOCAL:  camera_setup.focal  = csr_data[FOCAL_WIDTH-1:0];
               REG_SCREEN: camera_setup.screen = csr_data[SCREEN_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            fresh.word = project_vertex(req_point_x, req_point_y, req_point_z,
                                        camera_setup);
            fresh.seq  = vertex_count;
            expected_words.push_back(fresh);
            vertex_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("screen word with no vertex pending");
            end else begin
               oldest = expected_words.pop_front();
               if (rsp_screen_x !== oldest.word.screen_x) begin
                  report_mismatch($sformatf("vertex %0d screen_x %0d, predicted %0d",
                     oldest.seq, rsp_screen_x, $signed(oldest.word.screen_x)));
               end
               if (rsp_screen_y !== oldest.word.screen_y) begin
                  report_mismatch($sformatf("vertex %0d screen_y %0d, predicted %0d",
                     oldest.seq, rsp_screen_y, $signed(oldest.word.screen_y)));
               end
               if (rsp_view_depth !== oldest.word.view_depth) begin
                  report_mismatch($sformatf("vertex %0d view_depth %0d, predicted %0d",
                     oldest.seq, rsp_view_depth, $signed(oldest.word.view_depth)));
               end
               if (rsp_clipped !== oldest.word.clipped) begin
                  report_mismatch($sformatf("vertex %0d clipped %b, predicted %b",
                     oldest.seq, rsp_clipped, oldest.word.clipped));
               end
            end
         end
      end
      words_in_flight <= expected_words.size();
   end

endmodule

@@ bench/perspective_vertex_projector_unit_tb.sv @@
// ----------------------------------------------------------------------------
// perspective_vertex_projector_unit_tb
// stimulus and verdict for the vertex projector: a short set of corner
// vertices under the reset camera, then phases of random vertices, each
// under a freshly loaded camera setup, while the checker predicts and
// compares every screen word
// ----------------------------------------------------------------------------
module perspective_vertex_projector_unit_tb;
   import pvp_pkg::*;

   // camera setups that the phases load
   typedef enum int {
      SET_NEAR_IDENTITY,
      SET_FULL_RANDOM,
      SET_ALL_ONES,
      SET_ALL_ZEROS,
      SET_SIGNED_EDGE
   } setting_kind_type;

   // receiver stall behavior, picked anew at random when the current mode runs out
   typedef enum int {
      DRAIN_FREE,
      DRAIN_LIGHT,
      DRAIN_HEAVY,
      DRAIN_RUNS
   } drain_mode_type;

   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_VERTICES = 115;
   // wait beyond the pipeline drain so a stray extra word shows up
   localparam int DRAIN_CYCLES   = 40;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;

   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   logic signed [COORD_WIDTH-1:0] req_point_x = '0;
   logic signed [COORD_WIDTH-1:0] req_point_y = '0;
   logic signed [COORD_WIDTH-1:0] req_point_z = '0;

   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   logic signed [COORD_WIDTH-1:0] rsp_screen_x;
   logic signed [COORD_WIDTH-1:0] rsp_screen_y;
   logic signed [DEPTH_WIDTH-1:0] rsp_view_depth;
   logic                          rsp_clipped;

   logic                          csr_valid   = 1'b0;
   logic                          csr_ready;
   logic [CSR_ADDR_WIDTH-1:0]     csr_addr    = '0;
   logic [CSR_DATA_WIDTH-1:0]     csr_data    = '0;

   int unsigned                   mismatches;
   int unsigned                   words_in_flight;

   // camera z of the current setup, used to aim vertices in front of it
   logic signed [COORD_WIDTH-1:0] cam_z_now   = CAM_Z_RESET;

   // a mix of benign and extreme setups, near identity most often
   setting_kind_type phase_plan [PHASE_COUNT] = '{
      SET_NEAR_IDENTITY, SET_FULL_RANDOM, SET_ALL_ONES, SET_NEAR_IDENTITY,
      SET_ALL_ZEROS, SET_SIGNED_EDGE, SET_NEAR_IDENTITY, SET_FULL_RANDOM,
      SET_NEAR_IDENTITY, SET_NEAR_IDENTITY
   };

   // receiver stall pattern state
   drain_mode_type drain_mode = DRAIN_FREE;
   int             mode_left  = 0;
   int             run_left   = 0;
   logic           run_hold   = 1'b0;

   always #1 clock = ~clock;

   perspective_vertex_projector_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_screen_x   (rsp_screen_x),
      .rsp_screen_y   (rsp_screen_y),
      .rsp_view_depth (rsp_view_depth),
      .rsp_clipped    (rsp_clipped),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_addr       (csr_addr),
      .csr_data       (csr_data)
   );

   projection_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_view_depth  (rsp_view_depth),
      .rsp_clipped     (rsp_clipped),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_addr        (csr_addr),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .words_in_flight (words_in_flight)
   );

   // hard stop, far beyond the slowest legal run
   initial begin
      #800_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: free flowing, light or heavy random stalls, or long stall runs
   always @(posedge clock) begin
      if (mode_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(32, 400);
      end else begin
         mode_left--;
      end
      case (drain_mode)
         DRAIN_FREE:  rsp_stall <= 1'b0;
         DRAIN_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         DRAIN_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (run_left == 0) begin
               run_hold = ~run_hold;
               run_left = run_hold ? $urandom_range(1, 20) : $urandom_range(1, 10);
            end else begin
               run_left--;
            end
            rsp_stall <= run_hold;
         end
      endcase
   end

   // present one vertex word and hold it until the block takes it;
   // returns at the accepting edge with valid still high
   task automatic send_vertex(logic signed [COORD_WIDTH-1:0] x,
                              logic signed [COORD_WIDTH-1:0] y,
                              logic signed [COORD_WIDTH-1:0] z);
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (req_stall);
   endtask

   // csr valid stays high across back to back writes, the caller lowers it
   task automatic write_reg(csr_reg_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   function automatic logic [ROW_WIDTH-1:0] pack_row(int w_dx, int w_dy, int w_dz);
      return {COEF_WIDTH'(w_dz), COEF_WIDTH'(w_dy), COEF_WIDTH'(w_dx)};
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] corner_coord();
      case ($urandom_range(0, 5))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return '0;
         3:       return -1;
         4:       return 1;
         default: return COORD_WIDTH'($urandom);
      endcase
   endfunction

   // load all eight registers; upper data bits of the narrow ones get junk
   task automatic apply_setting(setting_kind_type kind);
      logic [ROW_WIDTH-1:0]    rows [3];
      logic [COORD_WIDTH-1:0]  cam [3];
      logic [FOCAL_WIDTH-1:0]  focal;
      logic [SCREEN_WIDTH-1:0] screen;
      int                      w [3];
      case (kind)
         SET_NEAR_IDENTITY: begin
            // mild rotation, camera near the origin, most vertices visible
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  w[j] = (i == j) ? 16384 + $urandom_range(0, 2048) - 1024
                                  : $urandom_range(0, 4096) - 2048;
               end
               rows[i] = pack_row(w[0], w[1], w[2]);
               cam[i]  = $urandom_range(0, 131072) - 65536;
            end
            focal  = $urandom_range(256, 1 << 20);
            screen = $urandom;
         end
         SET_FULL_RANDOM: begin
            for (int i = 0; i < 3; i++) begin
               rows[i] = {$urandom, $urandom};
               cam[i]  = $urandom;
            end
            focal  = $urandom;
            screen = $urandom;
         end
         SET_ALL_ONES: begin
            // tiny negative weights, largest focal length and screen
            rows   = '{default: '1};
            cam    = '{default: '1};
            focal  = '1;
            screen = '1;
         end
         SET_ALL_ZEROS: begin
            // zero depth everywhere, every vertex clips
            rows   = '{default: '0};
            cam    = '{default: '0};
            focal  = '0;
            screen = '0;
         end
         default: begin
            // weights at both signed limits, camera at the far corner
            rows[0] = pack_row(-32768, 32767, -32768);
            rows[1] = pack_row(32767, -32768, 32767);
            rows[2] = pack_row(32767, 32767, 32767);
            cam     = '{default: COORD_MIN};
            focal   = '1;
            screen  = '1;
         end
      endcase
      write_reg(REG_VIEW_X, rows[0]);
      write_reg(REG_VIEW_Y, rows[1]);
      write_reg(REG_VIEW_Z, rows[2]);
      write_reg(REG_CAM_X,  {COORD_WIDTH'($urandom), cam[0]});
      write_reg(REG_CAM_Y,  {COORD_WIDTH'($urandom), cam[1]});
      write_reg(REG_CAM_Z,  {COORD_WIDTH'($urandom), cam[2]});
      write_reg(REG_FOCAL,  {24'($urandom), focal});
      write_reg(REG_SCREEN, {24'($urandom), screen});
      csr_valid <= 1'b0;
      cam_z_now = cam[2];
   endtask

   // half the vertices in front of the camera, the rest full range, corners
   // and values close to zero
   task automatic send_random_vertex();
      logic signed [COORD_WIDTH-1:0] p [3];
      int                            pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         p[0] = $urandom_range(0, 131072) - 65536;
         p[1] = $urandom_range(0, 131072) - 65536;
         p[2] = int'(cam_z_now) + int'($urandom_range(0, 262144)) - 1024;
      end else begin
         for (int i = 0; i < 3; i++) begin
            if (pick < 8) begin
               p[i] = $urandom;
            end else if (pick < 9) begin
               p[i] = corner_coord();
            end else begin
               p[i] = $urandom_range(0, 2048) - 1024;
            end
         end
      end
      send_vertex(p[0], p[1], p[2]);
   endtask

   // bursts of random length, random gaps between them, sometimes none
   task automatic stream_vertices(int count);
      int burst_left;
      int gap;
      burst_left = 0;
      repeat (count) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         send_random_vertex();
      end
      req_valid <= 1'b0;
   endtask

   // every vertex gives one word, so an empty checker means an empty pipe
   task automatic wait_idle();
      do @(posedge clock); while (words_in_flight != 0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // corner vertices under the reset camera: identity view, camera at z -50
      send_vertex(0, 0, 0);                         // straight ahead, screen centre
      send_vertex(0, 0, -12544);                    // depth exactly on the near plane
      send_vertex(0, 0, -12545);                    // one lsb short of the near plane
      send_vertex(0, 0, -12800);                    // zero depth
      send_vertex(0, 0, COORD_MIN);                 // far behind the camera
      send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MAX);
      send_vertex(COORD_MAX, COORD_MIN, -12544);    // x and y saturate high
      send_vertex(COORD_MIN, COORD_MAX, -12544);    // x and y saturate low
      send_vertex(256, 256, 0);
      send_vertex(-256, -256, 0);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
      send_vertex(1, -1, 1);                        // rounding right at the centre
      send_vertex(-1, 1, -12544);
      req_valid <= 1'b0;

      // random phases, each under a new camera loaded while idle
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         apply_setting(phase_plan[p]);
         stream_vertices(PHASE_VERTICES);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
